>>> sv/tmbt_pkg.sv
`default_nettype none
package tmbt_pkg;

   localparam int MAX_EVENTS = 16;
   localparam int MAP_IDX_W  = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
   localparam int MAP_CNT_W  = $clog2(MAX_EVENTS + 1);

   localparam logic [16:0] TEMPO_MIN_Q8   = 17'd5120;
   localparam logic [16:0] TEMPO_MAX_Q8   = 17'd76800;
   localparam logic [16:0] TEMPO_RESET_Q8 = 17'd30720;
   localparam logic [25:0] US_PER_MINUTE  = 26'd60000000;

   // ceil(2^55 / 234375) split into two 19-bit halves
   localparam logic [18:0] RCP_M_HI = 19'd293203;
   localparam logic [18:0] RCP_M_LO = 19'd52817;

   localparam int DVD_W = 58;
   localparam int DVS_W = 32;

   localparam logic [3:0] OP_ADVANCE    = 4'd0;
   localparam logic [3:0] OP_PLAY       = 4'd1;
   localparam logic [3:0] OP_STOP       = 4'd2;
   localparam logic [3:0] OP_TOGGLE     = 4'd3;
   localparam logic [3:0] OP_SET_POS    = 4'd4;
   localparam logic [3:0] OP_SET_POS_SL = 4'd5;
   localparam logic [3:0] OP_SET_TEMPO  = 4'd6;
   localparam logic [3:0] OP_MAP_WRITE  = 4'd7;
   localparam logic [3:0] OP_MAP_SIZE   = 4'd8;

   localparam logic [1:0] CSR_LOOP_ON    = 2'd0;
   localparam logic [1:0] CSR_LOOP_FIRST = 2'd1;
   localparam logic [1:0] CSR_LOOP_LAST  = 2'd2;

   typedef struct packed {
      logic [3:0]         operation;
      logic [19:0]        elapsed_us;
      logic signed [31:0] beat_value;
      logic [16:0]        bpm_value;
      logic [3:0]         entry_index;
      logic [4:0]         entry_total;
   } req_type;

   typedef struct packed {
      logic [31:0] position;
      logic [16:0] current_bpm;
      logic        is_playing;
      logic        beat_crossed;
      logic        transport_changed;
   } rsp_type;

   typedef struct packed {
      logic [31:0] beat;
      logic [16:0] bpm;
   } map_entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_SCAN_RD, S_SCAN_CHK, S_WALK, S_MUL, S_DIV,
      S_FINAL, S_WRAP, S_CHECK, S_MAP_RD, S_MAP_WAIT, S_DONE,
      S_RCP_LO, S_RCP_HI, S_RCP_ADD
   } state_type;

   typedef enum logic [1:0] {DIV_SEG, DIV_MOD} div_kind_type;

   function automatic logic [16:0] clamp_bpm(input logic [16:0] v);
      if (v < TEMPO_MIN_Q8) return TEMPO_MIN_Q8;
      if (v > TEMPO_MAX_Q8) return TEMPO_MAX_Q8;
      return v;
   endfunction

   function automatic logic [31:0] clamp_beat(input logic signed [31:0] v);
      if (v[31]) return 32'd0;
      return v;
   endfunction

endpackage
`default_nettype wire

>>> sv/tmbt_map_ram.sv
`default_nettype none
module tmbt_map_ram (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire [tmbt_pkg::MAP_IDX_W-1:0] wr_addr,
   input  wire tmbt_pkg::map_entry_type wr_data,
   input  wire [tmbt_pkg::MAP_IDX_W-1:0] rd_addr,
   output tmbt_pkg::map_entry_type      rd_data
);
   import tmbt_pkg::*;

   map_entry_type mem [MAX_EVENTS];
   map_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> sv/tmbt_divider.sv
`default_nettype none
module tmbt_divider (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   input  wire [tmbt_pkg::DVD_W-1:0] dividend,
   input  wire [tmbt_pkg::DVS_W-1:0] divisor,
   output logic                      done,
   output logic [tmbt_pkg::DVD_W-1:0] quotient,
   output logic [tmbt_pkg::DVS_W-1:0] remainder
);
   import tmbt_pkg::*;

   localparam int CNT_W = $clog2(DVD_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] work_ff, work_in;
   logic [DVS_W-1:0] part_ff, part_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W+1:0] diff;

   always_comb begin
      shifted = {part_ff, work_ff[DVD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      part_in = part_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W - 1);
         work_in = dividend;
         part_in = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[DVD_W-2:0], ~diff[DVS_W+1]};
         part_in = diff[DVS_W+1] ? shifted[DVS_W-1:0] : diff[DVS_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      part_ff <= part_in;
      dvs_ff  <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = work_ff;
   assign remainder = part_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
endmodule
`default_nettype wire

>>> sv/tempo_map_beat_transport.sv
`default_nettype none
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_stall  | req_data  (operation and operands)
// rsp     | out       | rsp_valid / rsp_stall  | rsp_data  (position, tempo, flags)
// csr     | in        | csr_write_en           | csr_index, csr_wdata
//
// One request is worked on at a time.
// Advance: each tempo map entry is scanned in S_SCAN_RD and S_SCAN_CHK, and the
// map is rescanned from entry 0 after each segment crossed; each division runs in
// the shared 58-step restoring divider (one per segment, one for loop wrap); the
// final fraction uses reciprocal multiplication (S_RCP_LO, S_RCP_HI, S_RCP_ADD).
// Reset is synchronous, active high; the map RAM is not cleared.
// A new request is taken while the previous response still waits under rsp_stall.
module tempo_map_beat_transport (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire tmbt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output tmbt_pkg::rsp_type rsp_data,
   input  wire               csr_write_en,
   input  wire [1:0]         csr_index,
   input  wire [31:0]        csr_wdata
);
   import tmbt_pkg::*;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;

   logic                 running_ff, running_in;
   logic [31:0]          beat_pos_ff, beat_pos_in;
   logic [16:0]          tempo_ff, tempo_in;
   logic signed [16:0]   last_whole_ff, last_whole_in;
   logic [MAP_CNT_W-1:0] map_size_ff, map_size_in;
   logic                 loop_on_ff;
   logic [31:0]          loop_first_ff, loop_last_ff;

   logic [32:0]          pos_ff, pos_in;
   logic [27:0]          rem_ff, rem_in;
   logic [16:0]          bpm_ff, bpm_in;
   logic [31:0]          nx_beat_ff, nx_beat_in;
   logic [16:0]          nx_bpm_ff, nx_bpm_in;
   logic                 at_end_ff, at_end_in;
   logic                 first_scan_ff, first_scan_in;
   logic [MAP_CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic [44:0]          have_ff, have_in;
   logic [57:0]          need_ff, need_in;
   logic [56:0]          rcp_ff, rcp_in;
   div_kind_type         div_kind_ff, div_kind_in;
   logic                 crossed_ff, crossed_in;
   logic                 changed_ff, changed_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 ram_we;
   logic [MAP_IDX_W-1:0] ram_waddr, ram_raddr;
   map_entry_type        ram_wdata, ram_rdata;

   logic                 div_start, div_done;
   logic [DVD_W-1:0]     div_dividend, div_quot;
   logic [DVS_W-1:0]     div_divisor, div_rem;

   logic                 beat_gt_pos, wrap_hit, accept, rsp_free;
   logic [31:0]          sat_pos;
   logic [15:0]          whole;

   tmbt_map_ram u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   tmbt_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign beat_gt_pos = {1'b0, ram_rdata.beat} > pos_ff;
   assign sat_pos     = pos_ff[32] ? 32'hFFFF_FFFF : pos_ff[31:0];
   assign wrap_hit    = loop_on_ff && (pos_ff[31:0] >= loop_last_ff) &&
                        (loop_last_ff > loop_first_ff);
   assign whole       = pos_ff[31:16];
   assign ram_raddr   = (state_ff == S_MAP_RD) ? '0 : scan_idx_ff[MAP_IDX_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (accept) state_in = S_EXEC;
         S_EXEC: begin
            priority case (req_ff.operation)
               OP_ADVANCE: begin
                  if (!running_ff) state_in = S_DONE;
                  else if (map_size_ff == '0) state_in = S_WALK;
                  else state_in = S_SCAN_RD;
               end
               OP_MAP_WRITE, OP_MAP_SIZE: state_in = S_MAP_RD;
               default: state_in = S_DONE;
            endcase
         end
         S_SCAN_RD:  state_in = (scan_idx_ff == map_size_ff) ? S_WALK : S_SCAN_CHK;
         S_SCAN_CHK: state_in = beat_gt_pos ? S_WALK : S_SCAN_RD;
         S_WALK:     state_in = (rem_ff == '0) ? S_FINAL : S_MUL;
         S_MUL: begin
            if (at_end_ff || need_ff > {13'd0, have_ff}) state_in = S_RCP_LO;
            else state_in = S_DIV;
         end
         S_RCP_LO:   state_in = S_RCP_HI;
         S_RCP_HI:   state_in = S_RCP_ADD;
         S_RCP_ADD:  state_in = S_FINAL;
         S_DIV: begin
            if (div_done) begin
               unique case (div_kind_ff)
                  DIV_SEG: state_in = S_SCAN_RD;
                  default: state_in = S_CHECK;
               endcase
            end
         end
         S_FINAL:    state_in = S_WRAP;
         S_WRAP:     state_in = wrap_hit ? S_DIV : S_CHECK;
         S_CHECK:    state_in = S_DONE;
         S_MAP_RD:   state_in = (map_size_ff == '0) ? S_DONE : S_MAP_WAIT;
         S_MAP_WAIT: state_in = S_DONE;
         S_DONE:     if (rsp_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_in        = req_ff;
      running_in    = running_ff;
      beat_pos_in   = beat_pos_ff;
      tempo_in      = tempo_ff;
      last_whole_in = last_whole_ff;
      map_size_in   = map_size_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      bpm_in        = bpm_ff;
      nx_beat_in    = nx_beat_ff;
      nx_bpm_in     = nx_bpm_ff;
      at_end_in     = at_end_ff;
      first_scan_in = first_scan_ff;
      scan_idx_in   = scan_idx_ff;
      have_in       = have_ff;
      need_in       = need_ff;
      rcp_in        = rcp_ff;
      div_kind_in   = div_kind_ff;
      crossed_in    = crossed_ff;
      changed_in    = changed_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = MAP_IDX_W'(req_ff.entry_index);
      ram_wdata     = '{beat: clamp_beat(req_ff.beat_value),
                        bpm: clamp_bpm(req_ff.bpm_value)};
      div_start     = 1'b0;
      div_dividend  = {32'd0, US_PER_MINUTE};
      div_divisor   = {6'd0, US_PER_MINUTE};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in     = req_data;
               crossed_in = 1'b0;
               changed_in = 1'b0;
            end
         end
         S_EXEC: begin
            pos_in        = {1'b0, beat_pos_ff};
            rem_in        = {req_ff.elapsed_us, 8'd0};
            bpm_in        = tempo_ff;
            at_end_in     = 1'b1;
            first_scan_in = 1'b1;
            scan_idx_in   = '0;
            priority case (req_ff.operation)
               OP_PLAY: begin
                  if (!running_ff) begin
                     running_in = 1'b1;
                     changed_in = 1'b1;
                  end
               end
               OP_STOP: begin
                  if (running_ff) begin
                     running_in = 1'b0;
                     changed_in = 1'b1;
                  end
               end
               OP_TOGGLE: begin
                  running_in = !running_ff;
                  changed_in = 1'b1;
               end
               OP_SET_POS: begin
                  beat_pos_in   = clamp_beat(req_ff.beat_value);
                  last_whole_in = -17'sd1;
               end
               OP_SET_POS_SL: beat_pos_in = clamp_beat(req_ff.beat_value);
               OP_SET_TEMPO:  tempo_in = clamp_bpm(req_ff.bpm_value);
               OP_MAP_WRITE:  ram_we = (32'(req_ff.entry_index) < MAX_EVENTS);
               OP_MAP_SIZE: begin
                  map_size_in = (32'(req_ff.entry_total) > MAX_EVENTS) ?
                                MAP_CNT_W'(MAX_EVENTS) : MAP_CNT_W'(req_ff.entry_total);
               end
               default: ;
            endcase
         end
         S_SCAN_RD: begin
            if (scan_idx_ff == map_size_ff) at_end_in = 1'b1;
         end
         S_SCAN_CHK: begin
            if (first_scan_ff && (scan_idx_ff == '0 || !beat_gt_pos)) begin
               bpm_in = ram_rdata.bpm;
            end
            if (beat_gt_pos) begin
               at_end_in  = 1'b0;
               nx_beat_in = ram_rdata.beat;
               nx_bpm_in  = ram_rdata.bpm;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         S_WALK: begin
            have_in = rem_ff * bpm_ff;
            need_in = (nx_beat_ff - pos_ff[31:0]) * US_PER_MINUTE;
         end
         S_MUL: begin
            if (!(at_end_ff || need_ff > {13'd0, have_ff})) begin
               div_start    = 1'b1;
               div_kind_in  = DIV_SEG;
               div_dividend = need_ff;
               div_divisor  = {15'd0, bpm_ff};
            end
         end
         S_RCP_LO:  rcp_in = have_ff[44:8] * RCP_M_LO;
         S_RCP_HI:  rcp_in = have_ff[44:8] * RCP_M_HI + {20'd0, rcp_ff[55:19]};
         S_RCP_ADD: pos_in = pos_ff + {12'd0, rcp_ff[56:36]};
         S_DIV: begin
            if (div_done) begin
               unique case (div_kind_ff)
                  DIV_SEG: begin
                     rem_in        = (div_quot >= {30'd0, rem_ff}) ? '0 :
                                     rem_ff - div_quot[27:0];
                     pos_in        = {1'b0, nx_beat_ff};
                     bpm_in        = nx_bpm_ff;
                     scan_idx_in   = '0;
                     first_scan_in = 1'b0;
                  end
                  default: pos_in = {1'b0, loop_first_ff + div_rem};
               endcase
            end
         end
         S_FINAL: begin
            tempo_in = bpm_ff;
            pos_in   = {1'b0, sat_pos};
         end
         S_WRAP: begin
            if (wrap_hit) begin
               div_start    = 1'b1;
               div_kind_in  = DIV_MOD;
               div_dividend = {26'd0, pos_ff[31:0] - loop_first_ff};
               div_divisor  = loop_last_ff - loop_first_ff;
            end
         end
         S_CHECK: begin
            beat_pos_in = pos_ff[31:0];
            if ($signed({1'b0, whole}) > last_whole_ff) begin
               last_whole_in = $signed({1'b0, whole});
               crossed_in    = 1'b1;
            end
         end
         S_MAP_RD: ;
         S_MAP_WAIT: tempo_in = ram_rdata.bpm;
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{position: beat_pos_ff, current_bpm: tempo_ff,
                                is_playing: running_ff, beat_crossed: crossed_ff,
                                transport_changed: changed_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         running_ff    <= 1'b0;
         beat_pos_ff   <= '0;
         tempo_ff      <= TEMPO_RESET_Q8;
         last_whole_ff <= -17'sd1;
         map_size_ff   <= '0;
         loop_on_ff    <= 1'b0;
         loop_first_ff <= '0;
         loop_last_ff  <= 32'd1048576;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         running_ff    <= running_in;
         beat_pos_ff   <= beat_pos_in;
         tempo_ff      <= tempo_in;
         last_whole_ff <= last_whole_in;
         map_size_ff   <= map_size_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_LOOP_ON:    loop_on_ff    <= csr_wdata[0];
               CSR_LOOP_FIRST: loop_first_ff <= csr_wdata;
               CSR_LOOP_LAST:  loop_last_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
      req_ff        <= req_in;
      pos_ff        <= pos_in;
      rem_ff        <= rem_in;
      bpm_ff        <= bpm_in;
      nx_beat_ff    <= nx_beat_in;
      nx_bpm_ff     <= nx_bpm_in;
      at_end_ff     <= at_end_in;
      first_scan_ff <= first_scan_in;
      scan_idx_ff   <= scan_idx_in;
      have_ff       <= have_in;
      need_ff       <= need_in;
      rcp_ff        <= rcp_in;
      div_kind_ff   <= div_kind_in;
      crossed_ff    <= crossed_in;
      changed_ff    <= changed_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside done state");
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_CHK) |-> $past(state_ff == S_SCAN_RD))
      else $error("map data checked without a read");
   a_map_size: assert property (@(posedge clock) disable iff (reset)
      32'(map_size_ff) <= MAX_EVENTS) else $error("map size beyond depth");
endmodule
`default_nettype wire
